### sv/bloom_filter_insert_query_defines.svh
// Assertion macros shared by the RTL
`ifndef BLOOM_FILTER_INSERT_QUERY_DEFINES_SVH
`define BLOOM_FILTER_INSERT_QUERY_DEFINES_SVH
// assert that a implies b on the same edge
`define BFQ_ASSERT_IMP(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
// assert that a implies b on the next edge
`define BFQ_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`endif

### sv/bfq_pkg.sv
package bfq_pkg;
	localparam int unsigned DefMaxBits   = 1048576;
	localparam int unsigned DefMaxHashes = 8;
	localparam int unsigned BitCountW    = 21;
	localparam int unsigned NumHashesW   = 4;
	localparam logic [0:0] CfgBitCount  = 1'b0;
	localparam logic [0:0] CfgNumHashes = 1'b1;
	localparam logic OpInsert = 1'b0;
	localparam logic OpQuery  = 1'b1;

	function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned r);
		rotl32 = (x << r) | (x >> (32 - r));
	endfunction
endpackage

### sv/bfq_if.sv
interface bfq_in_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [31:0] key_word;
	logic [2:0]  valid_bytes;
	logic        last;
	modport source (output valid, op, key_word, valid_bytes, last, input ready);
	modport sink (input valid, op, key_word, valid_bytes, last, output ready);
endinterface

interface bfq_out_if;
	logic valid;
	logic ready;
	logic present;
	modport source (output valid, present, input ready);
	modport sink (input valid, present, output ready);
endinterface

### sv/bfq_divu.sv
// 32-bit by 21-bit restoring remainder, one quotient bit a cycle
module bfq_divu import bfq_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [31:0]          dividend,
	input  logic [BitCountW-1:0] divisor,
	output logic                 done,
	output logic [BitCountW-1:0] rem
);
	logic [31:0]          num_q;
	logic [BitCountW:0]   rem_q;
	logic [BitCountW-1:0] div_q;
	logic [5:0]           cnt_q;
	logic                 busy_q;
	logic [BitCountW:0]   trial;
	logic [BitCountW+1:0] diff;

	always_comb begin
		trial = {rem_q[BitCountW-1:0], num_q[31]};
		diff  = {1'b0, trial} - {2'b00, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				num_q  <= dividend;
				div_q  <= divisor;
				rem_q  <= '0;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				num_q <= num_q << 1;
				rem_q <= diff[BitCountW+1] ? trial : diff[BitCountW:0];
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	assign rem = rem_q[BitCountW-1:0];
endmodule

### sv/bloom_filter_insert_query.sv
// Non-last word: scramble through two multipliers (S_MIX1, S_MIX2), then lane
// mixing (S_MIX3). Last word: the same, then per hash lane finalize (S_FIN1-4),
// remainder (S_DIV), bit store read and, on insert, write; then S_DONE closes the key.
// One key end at a time; a query result waits in an output register.
// Reset clears control at once, then sweeps every row of the bit store, 32 bits
// a row; no input item is taken during the sweep.
module bloom_filter_insert_query import bfq_pkg::*; #(
	parameter int unsigned MAX_BITS   = DefMaxBits,
	parameter int unsigned MAX_HASHES = DefMaxHashes
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [0:0]           cfg_index,
	input  logic [BitCountW-1:0] cfg_wdata,
	bfq_in_if.sink               in_ch,
	bfq_out_if.source            out_ch
);
	`include "bloom_filter_insert_query_defines.svh"

	localparam int unsigned Rows  = (MAX_BITS + 31) / 32;
	localparam int unsigned RowW  = (Rows > 1) ? $clog2(Rows) : 1;
	localparam int unsigned LaneW = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
	localparam int unsigned IdxW  = $clog2(MAX_BITS) + 1;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_MIX1, S_MIX2, S_MIX3, S_FIN1, S_FIN2, S_FIN3, S_FIN4,
		S_DIV, S_RD, S_WR, S_DONE
	} state_t;

	state_t               state_q;
	logic [BitCountW-1:0] bit_count_q;
	logic [NumHashesW-1:0] num_hashes_q;
	logic [31:0]          lane_q [MAX_HASHES];
	logic [31:0]          len_q;
	logic [31:0]          k_q, t_q;
	logic                 op_q, last_q, all_q;
	logic [2:0]           vb_q;
	logic [LaneW-1:0]     lane_i_q;
	logic [NumHashesW:0]  lane_n_q;
	logic [RowW-1:0]      row_q;
	logic [4:0]           bit_q;
	logic                 div_start_q;
	logic                 div_done;
	logic [BitCountW-1:0] rem;
	logic [31:0]          mem [Rows];
	logic [31:0]          rd_q;
	logic                 out_valid_q, out_present_q;
	logic                 out_load;
	logic [BitCountW-1:0] m_eff;
	logic [NumHashesW:0]  n_eff;
	logic [31:0]          wmask;
	logic [IdxW-1:0]      idx_w;

	always_comb begin
		if (bit_count_q == '0) m_eff = BitCountW'(1);
		else if ({11'd0, bit_count_q} > 32'(MAX_BITS)) m_eff = BitCountW'(MAX_BITS);
		else m_eff = bit_count_q;
		if ({28'd0, num_hashes_q} > 32'(MAX_HASHES)) n_eff = (NumHashesW+1)'(MAX_HASHES);
		else n_eff = {1'b0, num_hashes_q};
		case (vb_q)
			3'd1: wmask = 32'h0000_00ff;
			3'd2: wmask = 32'h0000_ffff;
			3'd3: wmask = 32'h00ff_ffff;
			default: wmask = 32'hffff_ffff;
		endcase
		idx_w = IdxW'(rem);
	end

	bfq_divu u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start_q), .dividend(t_q),
		.divisor(m_eff), .done(div_done), .rem(rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_count_q  <= BitCountW'(1048576);
			num_hashes_q <= NumHashesW'(3);
		end else if (cfg_we) begin
			case (cfg_index)
				CfgBitCount:  bit_count_q <= cfg_wdata;
				CfgNumHashes: num_hashes_q <= cfg_wdata[NumHashesW-1:0];
				default: ;
			endcase
		end
	end

	// bit store: one write port, one registered read
	always_ff @(posedge clk) begin
		if (state_q == S_CLEAR) mem[row_q] <= '0;
		else if (state_q == S_WR && op_q == OpInsert) mem[row_q] <= rd_q | (32'd1 << bit_q);
		rd_q <= mem[row_q];
	end

	assign in_ch.ready    = (state_q == S_IDLE);
	assign out_ch.valid   = out_valid_q;
	assign out_ch.present = out_present_q;

	// load the answer once the output register is free or being drained
	assign out_load = (state_q == S_DONE) && (op_q == OpQuery) &&
		(!out_valid_q || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			row_q       <= '0;
			len_q       <= '0;
			out_valid_q <= 1'b0;
			div_start_q <= 1'b0;
			for (int i = 0; i < MAX_HASHES; i++) lane_q[i] <= 32'(i);
		end else begin
			div_start_q <= 1'b0;
			if (out_load) begin
				out_valid_q   <= 1'b1;
				out_present_q <= all_q;
			end else if (out_valid_q && out_ch.ready) out_valid_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					row_q <= row_q + RowW'(1);
					if (row_q == RowW'(Rows - 1)) state_q <= S_IDLE;
				end
				S_IDLE: if (in_ch.valid && in_ch.ready) begin
					op_q   <= in_ch.op;
					last_q <= in_ch.last;
					vb_q   <= (!in_ch.last || in_ch.valid_bytes > 3'd4) ? 3'd4
						: in_ch.valid_bytes;
					k_q    <= in_ch.key_word;
					state_q <= S_MIX1;
				end
				S_MIX1: begin
					k_q <= (k_q & wmask) * 32'hcc9e2d51;
					state_q <= S_MIX2;
				end
				S_MIX2: begin
					k_q <= rotl32(k_q, 15) * 32'h1b873593;
					state_q <= S_MIX3;
				end
				S_MIX3: begin
					for (int i = 0; i < MAX_HASHES; i++) begin
						if (vb_q == 3'd4)
							lane_q[i] <= rotl32(lane_q[i] ^ k_q, 13) * 32'd5 + 32'he6546b64;
						else if (vb_q != 3'd0)
							lane_q[i] <= lane_q[i] ^ k_q;
					end
					len_q    <= len_q + {29'd0, vb_q};
					lane_i_q <= '0;
					lane_n_q <= '0;
					all_q    <= 1'b1;
					state_q  <= last_q ? S_FIN1 : S_IDLE;
				end
				S_FIN1: begin
					if (lane_n_q == n_eff) begin
						state_q <= S_DONE;
					end else begin
						t_q <= lane_q[lane_i_q] ^ len_q;
						state_q <= S_FIN2;
					end
				end
				S_FIN2: begin
					t_q <= (t_q ^ (t_q >> 16)) * 32'h85ebca6b;
					state_q <= S_FIN3;
				end
				S_FIN3: begin
					t_q <= (t_q ^ (t_q >> 13)) * 32'hc2b2ae35;
					state_q <= S_FIN4;
				end
				S_FIN4: begin
					t_q <= t_q ^ (t_q >> 16);
					div_start_q <= 1'b1;
					state_q <= S_DIV;
				end
				S_DIV: if (div_done) begin
					row_q   <= RowW'(idx_w >> 5);
					bit_q   <= idx_w[4:0];
					state_q <= S_RD;
				end
				S_RD: state_q <= S_WR;
				S_WR: begin
					if (!rd_q[bit_q]) all_q <= 1'b0;
					lane_i_q <= lane_i_q + LaneW'(1);
					lane_n_q <= lane_n_q + (NumHashesW+1)'(1);
					state_q  <= S_FIN1;
				end
				S_DONE: begin
					// hold a query answer until the output register takes it
					if (op_q != OpQuery || out_load) begin
						for (int i = 0; i < MAX_HASHES; i++) lane_q[i] <= 32'(i);
						len_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`BFQ_ASSERT_IMP(a_no_accept_busy, clk, arst_n, state_q != S_IDLE, !in_ch.ready)
	`BFQ_ASSERT_NEXT(a_div_ends, clk, arst_n, div_done, state_q == S_RD)
	`BFQ_ASSERT_NEXT(a_query_result, clk, arst_n,
		state_q == S_DONE && op_q == OpQuery, out_valid_q)
	`BFQ_ASSERT_IMP(a_lane_bound, clk, arst_n, state_q == S_FIN2, lane_n_q < n_eff)
endmodule

### tb/tb_bloom_filter_insert_query.sv
module tb_bloom_filter_insert_query import bfq_pkg::*;;

	localparam int unsigned FILT_BITS = 1048576;
	localparam int unsigned LANES     = 8;
	localparam int unsigned SETTLE    = 500;

	typedef struct {
		int unsigned n;
		logic [31:0] w [6];
		logic [2:0]  vb;
	} key_t;

	class bloom_scoreboard;
		bit          filt [FILT_BITS];
		logic [31:0] lane [LANES];
		logic [31:0] len;
		logic [20:0] bit_count;
		logic [3:0]  num_hashes;
		bit          answers [$];
		int          errors;

		function new();
			bit_count  = 21'd1048576;
			num_hashes = 4'd3;
			errors     = 0;
			clear_lanes();
		endfunction

		function void clear_lanes();
			for (int i = 0; i < LANES; i++) lane[i] = i;
			len = 0;
		endfunction

		function logic [31:0] rot(logic [31:0] x, int r);
			return (x << r) | (x >> (32 - r));
		endfunction

		function logic [31:0] mix_word(logic [31:0] k);
			k = k * 32'hcc9e2d51;
			k = rot(k, 15);
			return k * 32'h1b873593;
		endfunction

		function logic [31:0] avalanche(logic [31:0] h);
			h = h ^ (h >> 16);
			h = h * 32'h85ebca6b;
			h = h ^ (h >> 13);
			h = h * 32'hc2b2ae35;
			return h ^ (h >> 16);
		endfunction

		function void note(logic op, logic [31:0] word, logic [2:0] vb_in, logic last);
			int unsigned vb, n, m, idx;
			logic [63:0] mask;
			logic [31:0] k;
			bit all_set;
			vb = (vb_in > 4 || !last) ? 4 : vb_in;
			all_set = 1;
			if (vb == 4) begin
				k = mix_word(word);
				for (int i = 0; i < LANES; i++)
					lane[i] = rot(lane[i] ^ k, 13) * 5 + 32'he6546b64;
			end else if (vb > 0) begin
				mask = (64'd1 << (8 * vb)) - 1;
				k = mix_word(word & mask[31:0]);
				for (int i = 0; i < LANES; i++) lane[i] ^= k;
			end
			len += vb;
			if (!last) return;
			n = (num_hashes > LANES) ? LANES : num_hashes;
			m = (bit_count == 0) ? 1 : (bit_count > FILT_BITS) ? FILT_BITS : bit_count;
			for (int i = 0; i < n; i++) begin
				idx = avalanche(lane[i] ^ len) % m;
				if (op == OpInsert) filt[idx] = 1;
				else if (!filt[idx]) all_set = 0;
			end
			clear_lanes();
			if (op == OpQuery) answers.push_back(all_set);
		endfunction

		function void check(logic present);
			bit want;
			if (answers.size() == 0) begin
				$display("%0t: unexpected result present=%b", $time, present);
				errors++;
				return;
			end
			want = answers.pop_front();
			if (present !== want) begin
				$display("%0t: present mismatch expected %b actual %b", $time, want, present);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [0:0]  cfg_index;
	logic [20:0] cfg_wdata;

	bfq_in_if  in_if ();
	bfq_out_if out_if ();

	bloom_filter_insert_query dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_if),
		.out_ch    (out_if)
	);

	bloom_scoreboard sb = new();
	int   idle_in;
	int   idle_out;
	bit   hold_req;
	int   words_sent;
	key_t key_pool [$];

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#40000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// receiver: check every transaction, then pick next ready
	initial begin
		int hold_left;
		hold_left = 0;
		out_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_if.valid && out_if.ready) sb.check(out_if.present);
			if (hold_req) begin
				hold_left = 800;
				hold_req  = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_if.ready <= 1'b0;
			end else
				out_if.ready <= ($urandom_range(99) >= idle_out);
		end
	end

	task automatic send_word(logic op, logic [31:0] word, logic [2:0] vb, logic last);
		while ($urandom_range(99) < idle_in) begin
			in_if.valid <= 1'b0;
			@(posedge clk);
		end
		in_if.valid       <= 1'b1;
		in_if.op          <= op;
		in_if.key_word    <= word;
		in_if.valid_bytes <= vb;
		in_if.last        <= last;
		do @(posedge clk); while (!in_if.ready);
		sb.note(op, word, vb, last);
		words_sent++;
	endtask

	// non-last words carry random op and byte count: both are ignored there
	task automatic send_key(logic op, key_t k);
		for (int i = 0; i < k.n - 1; i++)
			send_word($urandom_range(1), k.w[i], $urandom_range(7), 1'b0);
		send_word(op, k.w[k.n - 1], k.vb, 1'b1);
	endtask

	function automatic key_t random_key();
		key_t k;
		k.n  = ($urandom_range(9) == 0) ? $urandom_range(6, 4) : $urandom_range(3, 1);
		for (int i = 0; i < 6; i++) k.w[i] = $urandom;
		k.vb = $urandom_range(7);
		return k;
	endfunction

	task automatic settle();
		in_if.valid <= 1'b0;
		wait (sb.answers.size() == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_config(logic [20:0] bits, logic [3:0] hashes);
		cfg_we    <= 1'b1;
		cfg_index <= CfgBitCount;
		cfg_wdata <= bits;
		@(posedge clk);
		cfg_index <= CfgNumHashes;
		cfg_wdata <= 21'(hashes);
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.bit_count  = bits;
		sb.num_hashes = hashes;
	endtask

	task automatic directed();
		key_t k;
		k = random_key();
		k.n = 1; k.vb = 0;
		send_key(OpInsert, k);
		send_key(OpQuery, k);
		k.w[0] = '1; k.vb = 4;
		send_key(OpInsert, k);
		send_key(OpQuery, k);
		k.w[0] = '0;
		send_key(OpQuery, k);
		for (int v = 1; v < 8; v++) begin
			k.w[0] = $urandom; k.vb = v;
			send_key(OpInsert, k);
			send_key(OpQuery, k);
		end
		send_word(OpQuery, '1, 3'd0, 1'b0);
		send_word(OpInsert, '0, 3'd7, 1'b0);
		send_word(OpQuery, 32'h1234_5678, 3'd2, 1'b1);
	endtask

	initial begin
		logic [20:0] bits_set [7];
		logic [3:0]  hashes_set [7];
		key_t k;
		int   target;
		bit   held;
		bit   paused;
		bits_set   = '{21'd1048576, 21'd0, 21'd1, 21'd2097151, 21'd37, 21'd64, 21'd1000};
		hashes_set = '{4'd3, 4'd8, 4'd1, 4'd15, 4'd0, 4'd4, 4'd2};
		held       = 0;
		paused     = 0;
		cfg_we    <= 1'b0;
		cfg_index <= CfgBitCount;
		cfg_wdata <= '0;
		in_if.valid       <= 1'b0;
		in_if.op          <= OpInsert;
		in_if.key_word    <= '0;
		in_if.valid_bytes <= '0;
		in_if.last        <= 1'b0;
		arst_n     <= 1'b0;
		hold_req   = 0;
		idle_in    = 14;
		idle_out   = 79;
		words_sent = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int p = 0; p < 7; p++) begin
			if (p == 3) begin idle_in = 79; idle_out = 14; end
			if (p == 5) begin idle_in = 0;  idle_out = 0;  end
			if (p > 0) settle();
			write_config(bits_set[p], hashes_set[p]);
			key_pool.delete();
			if (p == 0 || p == 2) directed();
			target = words_sent + 136;
			while (words_sent < target) begin
				if (p == 4 && !held && words_sent >= target - 70) begin
					hold_req = 1;
					held     = 1;
				end
				if (p == 1 && !paused && words_sent >= target - 70) begin
					paused = 1;
					in_if.valid <= 1'b0;
					wait (sb.answers.size() == 0);
					@(posedge clk);
				end
				if (key_pool.size() > 0 && $urandom_range(1)) begin
					k = key_pool[$urandom_range(key_pool.size() - 1)];
					send_key($urandom_range(3) == 0 ? OpInsert : OpQuery, k);
				end else begin
					k = random_key();
					send_key($urandom_range(1), k);
					if (key_pool.size() < 40) key_pool.push_back(k);
				end
			end
		end
		settle();
		if (sb.errors == 0 && sb.answers.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
